>>> rtl/core/step_resetting_moving_average_macros.svh
// Assertion macros used by the moving average core
`ifndef STEP_RESETTING_MOVING_AVERAGE_MACROS_SVH
`define STEP_RESETTING_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication
`define SMAVG_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("smavg same-cycle check failed");

// next-cycle implication
`define SMAVG_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("smavg next-cycle check failed");

`endif

>>> rtl/core/smavg_pkg.sv
// Package: constants and types of the step-resetting moving average
package smavg_pkg;

    localparam int THR_W           = 20;
    localparam logic [THR_W-1:0] THR_RESET = 20'd1000;
    localparam int WINDOW_LOG2_DEF = 7;
    localparam int SAMPLE_BITS_DEF = 20;

    typedef struct packed {
        logic write;
        logic restart;
    } t_ring_ctl;

endpackage

>>> rtl/core/step_resetting_moving_average.sv
// Top level: step-resetting moving average with valid/stall channels
// Takes one sample per cycle while the output is not stalled; the sample is
// registered, then the step compare and running sum update sit between that
// register and the result register. The oldest ring entry is read from the
// sample memory into a read register ahead of use, so the single memory read
// port sustains one item per cycle. A restart refills the whole window at
// once by clearing the per-entry valid bits; entries not yet rewritten read
// as the restart sample. The user must write the step threshold only while
// the block is idle; the block itself does not enforce this.
module step_resetting_moving_average
    import smavg_pkg::*;
#(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output logic                          o_restarted,
    input  logic                          i_cfg_we,
    input  logic [THR_W-1:0]              i_cfg_data
);

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_average;
    logic                          r_out_restarted;
    logic [THR_W-1:0]              r_threshold;
    logic                          w_out_ready;
    logic                          w_fire;
    logic                          w_accept;
    t_ring_ctl                     w_ring_ctl;
    logic [SAMPLE_BITS-1:0]        w_old_data;
    logic                          w_old_valid;
    logic signed [SAMPLE_BITS-1:0] w_average;
    logic                          w_restarted;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_stall     = r_in_valid && !w_out_ready;
    assign w_accept    = i_valid && !o_stall;

    smavg_ring #(
        .WINDOW_LOG2(WINDOW_LOG2),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ring_ctl),
        .i_data     (r_in_sample),
        .o_old_data (w_old_data),
        .o_old_valid(w_old_valid)
    );

    smavg_core #(
        .WINDOW_LOG2(WINDOW_LOG2),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_sample   (r_in_sample),
        .i_threshold(r_threshold),
        .i_old_data (w_old_data),
        .i_old_valid(w_old_valid),
        .o_ring_ctl (w_ring_ctl),
        .o_average  (w_average),
        .o_restarted(w_restarted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= THR_RESET;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_sample <= i_sample;
        end
        if (w_fire) begin
            r_out_average   <= w_average;
            r_out_restarted <= w_restarted;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_average   = r_out_average;
    assign o_restarted = r_out_restarted;

endmodule

>>> rtl/core/smavg_ring.sv
// Sample ring: memory, per-entry valid bits and write position
module smavg_ring
    import smavg_pkg::*;
#(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ring_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_data,
    output logic [SAMPLE_BITS-1:0] o_old_data,
    output logic                   o_old_valid
);

    localparam int DEPTH = 1 << WINDOW_LOG2;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [DEPTH-1:0]       r_valid;
    logic [DEPTH-1:0]       n_valid;
    logic [WINDOW_LOG2-1:0] r_pos;
    logic [WINDOW_LOG2-1:0] n_pos;

    // read address follows the next position so the oldest entry is ready
    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        if (i_ctl.restart) begin
            n_pos   = '0;
            n_valid = '0;
        end else if (i_ctl.write) begin
            n_pos          = r_pos + 1'b1;
            n_valid[r_pos] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[r_pos] <= i_data;
        end
        r_rd_data <= r_mem[n_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= '0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    assign o_old_data  = r_rd_data;
    assign o_old_valid = r_valid[r_pos];

endmodule

>>> rtl/core/smavg_core.sv
// Average datapath: step detection, running sum, fill value
module smavg_core
    import smavg_pkg::*;
#(
    parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [THR_W-1:0]              i_threshold,
    input  logic [SAMPLE_BITS-1:0]        i_old_data,
    input  logic                          i_old_valid,
    output t_ring_ctl                     o_ring_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output logic                          o_restarted
);

`include "step_resetting_moving_average_macros.svh"

    localparam int SUM_W = SAMPLE_BITS + WINDOW_LOG2;
    localparam int DIF_W = SAMPLE_BITS + 1;
    localparam int CMP_W = (DIF_W > THR_W) ? DIF_W : THR_W;

    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SAMPLE_BITS-1:0] r_fill;
    logic                          r_primed;
    logic signed [SAMPLE_BITS-1:0] w_avg_cur;
    logic signed [DIF_W-1:0]       w_diff;
    logic [DIF_W-1:0]              w_mag;
    logic                          w_restart;
    logic signed [SAMPLE_BITS-1:0] w_old;

    assign w_avg_cur = $signed(r_sum[SUM_W-1:WINDOW_LOG2]);
    assign w_diff    = DIF_W'(w_avg_cur) - DIF_W'(i_sample);
    assign w_mag     = w_diff[DIF_W-1] ? DIF_W'(-w_diff) : DIF_W'(w_diff);
    assign w_restart = !r_primed || (CMP_W'(w_mag) > CMP_W'(i_threshold));
    assign w_old     = i_old_valid ? $signed(i_old_data) : r_fill;

    always_comb begin
        if (w_restart) begin
            n_sum = $signed({i_sample, {WINDOW_LOG2{1'b0}}});
        end else begin
            n_sum = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
        end
    end

    assign o_ring_ctl.write   = i_fire && !w_restart;
    assign o_ring_ctl.restart = i_fire && w_restart;
    assign o_average          = $signed(n_sum[SUM_W-1:WINDOW_LOG2]);
    assign o_restarted        = w_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_fill   <= '0;
            r_primed <= 1'b0;
        end else if (i_fire) begin
            r_sum    <= n_sum;
            r_primed <= 1'b1;
            if (w_restart) begin
                r_fill <= i_sample;
            end
        end
    end

    `SMAVG_ASSERT_SAME(a_first_restarts, i_clk, i_rst_n, i_fire && !r_primed, w_restart)
    `SMAVG_ASSERT_NEXT(a_refill_sum_aligned, i_clk, i_rst_n, i_fire && w_restart, r_sum[WINDOW_LOG2-1:0] == '0)
    `SMAVG_ASSERT_NEXT(a_refill_fill, i_clk, i_rst_n, i_fire && w_restart, r_fill == $past(i_sample))

endmodule
